@@ sv/drq_pkg.sv @@
// drq_pkg: shared types and codes for the dual queue shared ring unit
// no dependencies; imported by drq_ctrl and dual_queue_shared_ring_unit

package drq_pkg;

    // command codes carried in the input tuser
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam int DATA_OUT_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT,
        ST_WRITE,
        ST_RDWAIT,
        ST_RESULT
    } drq_state_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [DATA_OUT_W-1:0] data;
    } drq_res_t;

endpackage

@@ sv/dual_queue_shared_ring_unit.sv @@
// dual_queue_shared_ring_unit: top level, two fifo queues in one ring buffer
// depends on drq_pkg, drq_ram, drq_ctrl

// Two FIFO queues share one ring of DEPTH slots of DATA_WIDTH bits. Each
// queue keeps an empty head slot just before its first element and a tail
// slot at its last one; after reset queue 0 sits at slot 0 and queue 1 at
// slot DEPTH/2. One input transaction is one command: tuser bit 0 selects
// enqueue (0) or dequeue (1), tuser bit 1 picks the queue, tdata carries the
// value to enqueue (its low DATA_WIDTH bits are stored). Each command gives
// exactly one output transaction: tuser is the status (0 ok, 1 full, 2 empty)
// and tdata is the dequeued value on a good dequeue, zero otherwise. When an
// enqueue runs into the head of the other queue, the other queue is moved one
// slot forward element by element through the single ram port pair, so the
// block takes one command at a time. An enqueue that moves the other queue
// does one ram read-write per element of that queue, which holds fewer than
// DEPTH elements.
// The result waits in an output register, so a stalled consumer only delays
// the sequencer's final hand-off. The ring needs no clearing after reset.

module dual_queue_shared_ring_unit
    import drq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_in
    input  logic [1:0]  s_axis_tuser,   // cmd, queue_sel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_out
    output logic [1:0]  m_axis_tuser    // status
);

    localparam int AW = $clog2(DEPTH);

    // ring ram port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // sequencer result hand-off
    logic     res_valid;
    logic     res_ready;
    drq_res_t res;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [31:0] m_data_reg, m_data_next;
    logic        res_load;

    drq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    drq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser[0]),
        .in_sel    (s_axis_tuser[1]),
        .in_data   (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output slot is free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_axis_tready;
    assign res_load  = res_valid && res_ready;

    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        if (res_load)
        begin
            m_valid_next  = 1'b1;
            m_status_next = res.status;
            m_data_next   = res.data;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // one command at a time: no accept right after an accept
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while previous one in progress");

    // a result handed off by the sequencer shows up on the output next cycle
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> m_axis_tvalid && m_axis_tdata == $past(res.data)
            && m_axis_tuser == $past(res.status))
        else $error("result not registered on output");

    // status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_FULL
            || m_axis_tuser == STAT_EMPTY))
        else $error("undefined status code");

    // refused commands carry zero data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
        else $error("refused command returned nonzero data");
`endif

endmodule

@@ sv/drq_ram.sv @@
// drq_ram: ring buffer storage, one write port and one registered read port
// no dependencies

module drq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ sv/drq_ctrl.sv @@
// drq_ctrl: sequencer and slot pointers for the two queues; drives the ring ram
// depends on drq_pkg

module drq_ctrl
    import drq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_cmd,
    input  logic                  in_sel,
    input  logic [DATA_OUT_W-1:0] in_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output drq_res_t              res,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [DATA_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [DATA_WIDTH-1:0] ram_rdata
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] HALF = AW'(DEPTH / 2);

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    drq_state_t state_reg, state_next;

    logic                  cmd_reg,  cmd_next;
    logic                  sel_reg,  sel_next;
    logic [DATA_OUT_W-1:0] din_reg,  din_next;
    logic [AW-1:0]         head_reg [2];
    logic [AW-1:0]         head_next [2];
    logic [AW-1:0]         tail_reg [2];
    logic [AW-1:0]         tail_next [2];
    logic [AW-1:0]         j_reg,    j_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         wa_reg,   wa_next;
    logic [1:0]            status_reg, status_next;
    logic [DATA_OUT_W-1:0] dout_reg, dout_next;

    logic          oth;
    logic [AW-1:0] hq, tq, ho, to;
    logic          tail_meets;
    logic          oth_stuck;
    logic          q_empty;
    logic          walk_done;

    assign oth        = ~sel_reg;
    assign hq         = head_reg[sel_reg];
    assign tq         = tail_reg[sel_reg];
    assign ho         = head_reg[oth];
    assign to         = tail_reg[oth];
    assign tail_meets = (tq == ho);
    assign oth_stuck  = (to == hq);
    assign q_empty    = (tq == hq);
    assign walk_done  = (j_reg == ho);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (cmd_reg == CMD_ENQ)
                begin
                    if (!tail_meets)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (oth_stuck)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else
                begin
                    state_next = q_empty ? ST_RESULT : ST_RDWAIT;
                end
            end
            ST_SHIFT:
            begin
                if (walk_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:  state_next = ST_RESULT;
            ST_RDWAIT: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_next    = cmd_reg;
        sel_next    = sel_reg;
        din_next    = din_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        j_next      = j_reg;
        pend_next   = 1'b0;
        wa_next     = wa_reg;
        status_next = status_reg;
        dout_next   = dout_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        // pending shift write lands in the cycle after its read
        ram_we      = pend_reg;
        ram_waddr   = wa_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_cmd;
                    sel_next = in_sel;
                    din_next = in_data;
                end
            end
            ST_EVAL:
            begin
                status_next = STAT_OK;
                dout_next   = '0;
                if (cmd_reg == CMD_ENQ)
                begin
                    if (tail_meets && oth_stuck)
                    begin
                        status_next = STAT_FULL;
                    end
                    else if (tail_meets)
                    begin
                        j_next = to;
                    end
                end
                else if (q_empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    ram_raddr          = slot_next(hq);
                    head_next[sel_reg] = slot_next(hq);
                end
            end
            ST_SHIFT:
            begin
                if (!walk_done)
                begin
                    ram_raddr = j_reg;
                    pend_next = 1'b1;
                    wa_next   = slot_next(j_reg);
                    j_next    = slot_prev(j_reg);
                end
                else
                begin
                    head_next[oth] = slot_next(ho);
                    tail_next[oth] = slot_next(to);
                end
            end
            ST_WRITE:
            begin
                tail_next[sel_reg] = slot_next(tq);
                ram_we             = 1'b1;
                ram_waddr          = slot_next(tq);
                ram_wdata          = DATA_WIDTH'(din_reg);
            end
            ST_RDWAIT:
            begin
                dout_next = DATA_OUT_W'(ram_rdata);
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.data   = dout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg[0] <= '0;
            head_reg[1] <= HALF;
            tail_reg[0] <= '0;
            tail_reg[1] <= HALF;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        sel_reg    <= sel_next;
        din_reg    <= din_next;
        j_reg      <= j_next;
        wa_reg     <= wa_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

endmodule

@@ tb/sv/tb_dual_queue_shared_ring_unit.sv @@
`timescale 1ns / 1ps
// tb_dual_queue_shared_ring_unit: self-checking testbench for the two-queue ring unit
// depends on drq_pkg and dual_queue_shared_ring_unit; a built-in ring predictor checks every reply

module tb_dual_queue_shared_ring_unit;
    import drq_pkg::*;

    localparam int RING_SLOTS     = 16;
    localparam int RANDOM_CMDS    = 400;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;
    // worst case per command: a full shift plus sender gap plus receiver stall,
    // taken many times over
    localparam int CYCLE_LIMIT    = 200000;

    // one row of the directed table; want is only used where pinned is set
    typedef struct packed {
        logic     cmd;
        logic     qsel;
        logic [31:0] val;
        bit       pinned;
        drq_res_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor copy of the ring and of both queue pointers
    logic [31:0] ring_mem [RING_SLOTS] = '{default: '0};
    int          q_head [2] = '{0, RING_SLOTS / 2};
    int          q_tail [2] = '{0, RING_SLOTS / 2};

    // replies still owed by the block, oldest first
    drq_res_t    awaited_replies [$];

    int cycle_count      = 0;
    int mismatch_count   = 0;
    int replies_checked  = 0;
    int cmds_sent        = 0;
    int shift_moves      = 0;
    int shift_empty_moves = 0;
    int enq_full_seen    = 0;
    int deq_empty_seen   = 0;

    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;
    int rx_phase         = 0;

    logic [31:0] corner_vals [4] = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000};

    // after reset: empty refusals, extremes of the data field, fifo order,
    // a shift of an empty queue, a shift of a loaded one, then a full ring
    // refusing both queues
    stim_row_t directed_rows [24] = '{
        '{CMD_DEQ, 1'b0, 32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0000_0000}},
        '{CMD_DEQ, 1'b1, 32'hffff_ffff, 1'b1, '{STAT_EMPTY, 32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h7fff_ffff, 1'b1, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h8000_0000, 1'b1, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h0000_0000, 1'b1, '{STAT_OK,    32'h0000_0000}},
        '{CMD_DEQ, 1'b0, 32'h0000_0000, 1'b1, '{STAT_OK,    32'h7fff_ffff}},
        '{CMD_DEQ, 1'b1, 32'h0000_0000, 1'b1, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'hffff_ffff, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h0000_0001, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'ha5a5_a5a5, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h5a5a_5a5a, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h0000_ffff, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'hffff_0000, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h1234_5678, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h8765_4321, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h1357_9bdf, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'h2468_ace0, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h0000_0080, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h0100_0000, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'hffff_fffe, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h4000_0000, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h0000_0002, 1'b0, '{STAT_OK,    32'h0000_0000}},
        '{CMD_ENQ, 1'b0, 32'hcafe_f00d, 1'b1, '{STAT_FULL,  32'h0000_0000}},
        '{CMD_ENQ, 1'b1, 32'h0bad_c0de, 1'b1, '{STAT_FULL,  32'h0000_0000}}
    };

    dual_queue_shared_ring_unit #(
        .DEPTH      (RING_SLOTS),
        .DATA_WIDTH (32)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // data_in
        .s_axis_tuser  (s_axis_tuser),   // cmd, queue_sel
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // data_out
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int ring_next(int p);
        return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
    endfunction

    // elements held by one queue, counted from its empty head slot
    function automatic int queue_fill(int q);
        return (q_tail[q] - q_head[q] + RING_SLOTS) % RING_SLOTS;
    endfunction

    // apply one command to the predicted ring and return the reply it causes
    function automatic drq_res_t ring_apply_cmd(logic cmd, logic qsel, logic [31:0] val);
        int       q;
        int       o;
        int       j;
        int       guard;
        drq_res_t r;
        q = qsel;
        o = 1 - q;
        r.status = STAT_OK;
        r.data = '0;
        if (cmd == CMD_ENQ)
        begin
            if (q_tail[q] == q_head[o])
            begin
                if (q_tail[o] == q_head[q])
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (q_tail[o] == q_head[o])
                        shift_empty_moves++;
                    else
                        shift_moves++;
                    // push the other queue one slot on, last element first
                    j = q_tail[o];
                    guard = 0;
                    while (j != q_head[o] && guard < RING_SLOTS)
                    begin
                        ring_mem[ring_next(j)] = ring_mem[j];
                        j = (j == 0) ? RING_SLOTS - 1 : j - 1;
                        guard++;
                    end
                    q_head[o] = ring_next(q_head[o]);
                    q_tail[o] = ring_next(q_tail[o]);
                end
            end
            if (r.status == STAT_OK)
            begin
                q_tail[q] = ring_next(q_tail[q]);
                ring_mem[q_tail[q]] = val;
            end
            else
            begin
                enq_full_seen++;
            end
        end
        else
        begin
            if (q_tail[q] == q_head[q])
            begin
                r.status = STAT_EMPTY;
                deq_empty_seen++;
            end
            else
            begin
                q_head[q] = ring_next(q_head[q]);
                r.data = ring_mem[q_head[q]];
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        // keep the log short on a badly broken build, but count everything
        if (mismatch_count < 40)
            $display("mismatch at reply %0d: %s got %h want %h", replies_checked, what, got,
                     want);
        mismatch_count++;
    endtask

    // offer one command and hold it until the block takes it; the expected
    // reply is queued at the edge of the transaction
    task automatic issue_cmd(logic cmd, logic qsel, logic [31:0] val, bit pinned,
                             drq_res_t typed);
        drq_res_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {qsel, cmd};
        s_axis_tdata  <= val;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = ring_apply_cmd(cmd, qsel, val);
        awaited_replies.push_back(pinned ? typed : predicted);
        cmds_sent++;
    endtask

    // reply side: check each output transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                flag_mismatch("unexpected reply, status", {30'd0, m_axis_tuser}, 32'hx);
            end
            else
            begin
                drq_res_t want;
                want = awaited_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    flag_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, want.status});
                if (m_axis_tdata !== want.data)
                    flag_mismatch("data_out", m_axis_tdata, want.data);
            end
            replies_checked++;
        end
    end

    // receiver: rotates through stall patterns, and on request holds off for a
    // long stretch so the block backs up into its input
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            m_axis_tready <= 1'b0;
            holdoff_left  <= holdoff_left - 1;
        end
        else if (holdoff_served != holdoff_requests)
        begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= HOLDOFF_CYCLES;
            m_axis_tready  <= 1'b0;
        end
        else
        begin
            rx_phase <= rx_phase + 1;
            case ((rx_phase / 64) % 4)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                     awaited_replies.size());
            $display("dual_queue_shared_ring_unit test failed");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          gap;
        int          burst_left;
        int          enq_pct;
        int          favored;
        logic        cmd;
        logic        qsel;
        logic [31:0] val;

        burst_left = 0;
        enq_pct = 50;
        favored = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, back to back
        foreach (directed_rows[i])
            issue_cmd(directed_rows[i].cmd, directed_rows[i].qsel, directed_rows[i].val,
                      directed_rows[i].pinned, directed_rows[i].want);

        // random part: phases that lean toward filling, draining or mixing,
        // with one queue favored so the other gets pushed around the ring
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ((n / 40) % 3)
                    0:       enq_pct = 85;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                favored = $urandom_range(0, 1);
            end
            if (n == 120 || n == 330)
                holdoff_requests++;
            if (n == 220 || n == 380)
            begin
                // let the block run dry before going on
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (awaited_replies.size() != 0);
                burst_left = $urandom_range(1, 12);
            end
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;

            cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            qsel = ($urandom_range(0, 3) != 0) ? favored[0] : !favored[0];
            val  = ($urandom_range(0, 7) == 0) ? corner_vals[$urandom_range(0, 3)] : $urandom();
            // a queue that wraps onto itself while the other is empty locks the
            // ring for good; that case is saved for the end of the run
            if (cmd == CMD_ENQ && queue_fill(qsel) == RING_SLOTS - 1 && queue_fill(!qsel) == 0)
                cmd = CMD_DEQ;
            issue_cmd(cmd, qsel, val, 1'b0, '0);
        end

        // empty queue 1, then keep loading queue 0 until it wraps onto its own
        // head; from then on every command is refused
        repeat (RING_SLOTS) issue_cmd(CMD_DEQ, 1'b1, $urandom(), 1'b0, '0);
        repeat (RING_SLOTS + 1) issue_cmd(CMD_ENQ, 1'b0, $urandom(), 1'b0, '0);
        issue_cmd(CMD_DEQ, 1'b0, $urandom(), 1'b0, '0);
        issue_cmd(CMD_DEQ, 1'b1, $urandom(), 1'b0, '0);
        issue_cmd(CMD_ENQ, 1'b1, $urandom(), 1'b0, '0);

        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        // catch any stray reply after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands: %0d pushes of a loaded queue, %0d of an empty one",
                 cmds_sent, shift_moves, shift_empty_moves);
        $display("%0d full refusals, %0d empty refusals, %0d replies checked",
                 enq_full_seen, deq_empty_seen, replies_checked);
        if (mismatch_count == 0)
            $display("dual_queue_shared_ring_unit test passed");
        else
            $display("dual_queue_shared_ring_unit test failed");
        $finish;
    end

endmodule
